// ===== hw/rtl/sgr_pkg.sv =====
// package with grid geometry, widths and controller/datapath interface types
`timescale 1ns / 1ps
package sgr_pkg;
    localparam int GRID_ROWS  = 256;
    localparam int GRID_COLS  = 256;
    localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;
    localparam int ROW_W      = $clog2(GRID_ROWS);
    localparam int COL_W      = $clog2(GRID_COLS);
    localparam int ADDR_W     = $clog2(GRID_CELLS);
    localparam int CELL_W     = 16;
    localparam int SWEEP_W    = 32;
    localparam int IN_W       = 32;
    localparam int OUT_W      = 72;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_RELAX = 2'd2;

    localparam logic [2:0] PH_CENTER = 3'd0;
    localparam logic [2:0] PH_LEFT   = 3'd1;
    localparam logic [2:0] PH_RIGHT  = 3'd2;
    localparam logic [2:0] PH_UP     = 3'd3;
    localparam logic [2:0] PH_DOWN   = 3'd4;
    localparam logic [2:0] PH_WRITE  = 3'd5;

    typedef struct packed {
        logic       clear;
        logic       accept;
        logic       sweep;
        logic [2:0] phase;
        logic       sweep_init;
        logic       swap;
        logic       load_zero;
        logic       load_read;
        logic       load_relax;
    } t_dp_cmd;

    typedef struct packed {
        logic last_cell;
        logic changed;
    } t_dp_stat;
endpackage

// ===== hw/rtl/sandpile_grid_relaxation.sv =====
// top level of the sandpile grid relaxation block
`timescale 1ns / 1ps
// a write item loads its zero result into the output register when accepted; a read item
// passes the grid read register and S_READ state, no beat taken meanwhile; writes go one
// beat per cycle while results are taken; relax sweeps all cells until no cell changes
// a new beat enters once the waiting result is taken, at the earliest in that same cycle
// after reset a clearing pass zeroes both grids, no beats accepted
// synchronous active-low reset clears control state and selects grid a
module sandpile_grid_relaxation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // op[1:0], row[9:2], col[17:10], grains[25:18]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata   // cell_value[15:0], red, green, blue, sweep_count[71:40]
);
    import sgr_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    sgr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_op        (s_axis_tdata[1:0]),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    sgr_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_op     (s_axis_tdata[1:0]),
        .i_row    (s_axis_tdata[9:2]),
        .i_col    (s_axis_tdata[17:10]),
        .i_grains (s_axis_tdata[25:18]),
        .o_stat   (stat),
        .o_result (m_axis_tdata)
    );
endmodule

// ===== hw/rtl/sgr_ctrl.sv =====
// controller state machine for clearing, item handling and sweep sequencing
`timescale 1ns / 1ps
module sgr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_op,
    input  logic            i_out_ready,
    input  sgr_pkg::t_dp_stat i_stat,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output sgr_pkg::t_dp_cmd  o_cmd
);
    import sgr_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_SWEEP  = 3'd3;
    localparam logic [2:0] S_SWAP   = 3'd4;
    localparam logic [2:0] S_DECIDE = 3'd5;

    logic [2:0] r_state, n_state;
    logic [2:0] r_phase, n_phase;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = o_in_ready && i_in_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.phase = r_phase;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.last_cell) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    case (i_op)
                        OP_READ: n_state = S_READ;
                        OP_RELAX: begin
                            o_cmd.sweep_init = 1'b1;
                            n_phase          = PH_CENTER;
                            n_state          = S_SWEEP;
                        end
                        default: begin
                            o_cmd.load_zero = 1'b1;
                            n_out_valid     = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                o_cmd.load_read = 1'b1;
                n_out_valid     = 1'b1;
                n_state         = S_IDLE;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (r_phase == PH_WRITE) begin
                    n_phase = PH_CENTER;
                    if (i_stat.last_cell) n_state = S_SWAP;
                end else begin
                    n_phase = r_phase + 3'd1;
                end
            end
            S_SWAP: begin
                o_cmd.swap = 1'b1;
                n_state    = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.changed) begin
                    o_cmd.sweep_init = 1'b1;
                    n_state          = S_SWEEP;
                end else begin
                    o_cmd.load_relax = 1'b1;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_phase     <= PH_CENTER;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

// ===== hw/rtl/sgr_dp.sv =====
// datapath with the two grid memories, sweep counters, accumulator and result register
`timescale 1ns / 1ps
module sgr_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sgr_pkg::t_dp_cmd          i_cmd,
    input  logic [1:0]                i_op,
    input  logic [7:0]                i_row,
    input  logic [7:0]                i_col,
    input  logic [7:0]                i_grains,
    output sgr_pkg::t_dp_stat         o_stat,
    output logic [sgr_pkg::OUT_W-1:0] o_result
);
    import sgr_pkg::*;

    logic [CELL_W-1:0] grid_a [GRID_CELLS];
    logic [CELL_W-1:0] grid_b [GRID_CELLS];

    logic [CELL_W-1:0]  r_rd_a, r_rd_b;
    logic               r_cur_b;
    logic [ADDR_W-1:0]  r_addr;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic               r_nb_ok;
    logic               r_inside;
    logic [CELL_W-1:0]  r_acc;
    logic [CELL_W-1:0]  r_center;
    logic               r_changed;
    logic [SWEEP_W-1:0] r_sweeps;
    logic [CELL_W-1:0]  r_cell;
    logic [7:0]         r_red, r_green, r_blue;
    logic [SWEEP_W-1:0] r_sweep_out;

    logic              in_grid;
    logic [31:0]       lin;
    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              nb_ok;
    logic [CELL_W-1:0] rd;
    logic [CELL_W-1:0] term;
    logic [CELL_W-1:0] new_val;
    logic              we_a, we_b;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              last_cell;

    assign in_grid = (32'(i_row) < 32'(GRID_ROWS)) && (32'(i_col) < 32'(GRID_COLS));
    assign lin     = 32'(i_row) * 32'(GRID_COLS) + 32'(i_col);
    assign in_addr = lin[ADDR_W-1:0];
    assign rd      = r_cur_b ? r_rd_b : r_rd_a;
    assign term    = r_nb_ok ? (rd >> 2) : '0;
    assign new_val = r_acc + term;
    assign last_cell = (r_addr == ADDR_W'(GRID_CELLS - 1));

    assign o_stat.last_cell = last_cell;
    assign o_stat.changed   = r_changed;
    assign o_result = {r_sweep_out, r_blue, r_green, r_red, r_cell};

    always_comb begin
        rd_addr = r_addr;
        nb_ok   = 1'b1;
        if (i_cmd.accept) begin
            rd_addr = in_addr;
        end else begin
            case (i_cmd.phase)
                PH_LEFT: begin
                    rd_addr = r_addr - ADDR_W'(1);
                    nb_ok   = (r_col != '0);
                end
                PH_RIGHT: begin
                    rd_addr = r_addr + ADDR_W'(1);
                    nb_ok   = (r_col != COL_W'(GRID_COLS - 1));
                end
                PH_UP: begin
                    rd_addr = r_addr - ADDR_W'(GRID_COLS);
                    nb_ok   = (r_row != '0);
                end
                PH_DOWN: begin
                    rd_addr = r_addr + ADDR_W'(GRID_COLS);
                    nb_ok   = (r_row != ROW_W'(GRID_ROWS - 1));
                end
                default: begin
                    rd_addr = r_addr;
                    nb_ok   = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        we_a    = 1'b0;
        we_b    = 1'b0;
        wr_addr = r_addr;
        wr_data = '0;
        if (i_cmd.clear) begin
            we_a = 1'b1;
            we_b = 1'b1;
        end else if (i_cmd.accept && i_op == OP_WRITE && in_grid) begin
            wr_addr = in_addr;
            wr_data = CELL_W'(i_grains);
            we_a    = !r_cur_b;
            we_b    = r_cur_b;
        end else if (i_cmd.sweep && i_cmd.phase == PH_WRITE) begin
            wr_data = new_val;
            we_a    = r_cur_b;
            we_b    = !r_cur_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_a) grid_a[wr_addr] <= wr_data;
        r_rd_a <= grid_a[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) grid_b[wr_addr] <= wr_data;
        r_rd_b <= grid_b[rd_addr];
    end

    // cell walk counters, shared by the clearing pass and the sweeps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_cmd.sweep_init) begin
            r_addr <= '0;
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_cmd.clear || (i_cmd.sweep && i_cmd.phase == PH_WRITE)) begin
            if (last_cell) begin
                r_addr <= '0;
                r_row  <= '0;
                r_col  <= '0;
            end else begin
                r_addr <= r_addr + ADDR_W'(1);
                if (r_col == COL_W'(GRID_COLS - 1)) begin
                    r_col <= '0;
                    r_row <= r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_b   <= 1'b0;
            r_changed <= 1'b0;
            r_sweeps  <= '0;
        end else begin
            if (i_cmd.accept) r_sweeps <= '0;
            if (i_cmd.accept || (i_cmd.sweep_init && !i_cmd.accept)) r_changed <= 1'b0;
            if (i_cmd.sweep && i_cmd.phase == PH_WRITE && new_val != r_center) begin
                r_changed <= 1'b1;
            end
            if (i_cmd.swap) begin
                r_cur_b <= !r_cur_b;
                if (r_sweeps != '1) r_sweeps <= r_sweeps + SWEEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_nb_ok <= nb_ok;
        if (i_cmd.accept) r_inside <= in_grid;
        if (i_cmd.sweep) begin
            case (i_cmd.phase)
                PH_LEFT: begin
                    r_acc    <= {{(CELL_W-2){1'b0}}, rd[1:0]};
                    r_center <= rd;
                end
                PH_RIGHT, PH_UP, PH_DOWN: r_acc <= new_val;
                default: r_acc <= r_acc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_zero || i_cmd.load_relax) begin
            r_cell  <= '0;
            r_red   <= '0;
            r_green <= '0;
            r_blue  <= '0;
        end
        if (i_cmd.load_zero) r_sweep_out <= '0;
        if (i_cmd.load_relax) r_sweep_out <= r_sweeps;
        if (i_cmd.load_read) begin
            r_sweep_out <= '0;
            r_cell      <= r_inside ? rd : '0;
            r_red       <= (r_inside && rd == CELL_W'(3)) ? 8'd255 : 8'd0;
            r_green     <= (r_inside && rd == CELL_W'(1)) ? 8'd255 : 8'd0;
            r_blue      <= (r_inside && rd == CELL_W'(2)) ? 8'd255 : 8'd0;
        end
    end
endmodule
